// ===== rtl/turbo_whistle_voice_assert.svh =====
// Assertion macros for the turbo whistle voice.
`ifndef TURBO_WHISTLE_VOICE_ASSERT_SVH
`define TURBO_WHISTLE_VOICE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is high.
`define TWV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define TWV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWV_ASSERT(lbl, clk, rst, prop, msg)
`define TWV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/twv_pkg.sv =====
package twv_pkg;

   localparam int PHASE_BITS_DEF      = 16;
   localparam int SINE_TABLE_BITS_DEF = 8;
   localparam int SAMPLE_BITS_DEF     = 16;

   localparam int NUM_CSR   = 7;
   localparam int CSR_IDX_W = 3;

   localparam logic [15:0] BASE_STEP_RST  = 16'd2731;
   localparam logic [15:0] RANGE_STEP_RST = 16'd0;
   localparam logic [15:0] NOISE_MIX_RST  = 16'd0;
   localparam logic [15:0] MAX_AMP_RST    = 16'd0;
   localparam logic [15:0] SPOOL_UP_RST   = 16'd3;
   localparam logic [15:0] SPOOL_DN_RST   = 16'd5;
   localparam logic [15:0] NOISE_COEF_RST = 16'd59022;

   localparam logic [31:0] SEED0 = 32'd98765432;
   localparam logic [31:0] SEED1 = 32'd456789012;
   localparam logic [31:0] SEED2 = 32'd321654987;
   localparam logic [31:0] SEED3 = 32'd112233445;

   // amplitude below 0.0001 in Q1.31
   localparam logic [31:0] AMP_FLOOR  = 32'd214749;
   // 0.02 in Q0.16
   localparam logic [10:0] JITTER_Q16 = 11'd1311;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_STEP  = 3'd0,
      CSR_RANGE_STEP = 3'd1,
      CSR_NOISE_MIX  = 3'd2,
      CSR_MAX_AMP    = 3'd3,
      CSR_SPOOL_UP   = 3'd4,
      CSR_SPOOL_DN   = 3'd5,
      CSR_NOISE_COEF = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_TGT, OP_DIFF, OP_SPOOL, OP_SQ, OP_AMP, OP_CHK,
      OP_STEP, OP_J1, OP_J2, OP_JIT, OP_NC, OP_FILT, OP_MIXN, OP_SIG,
      OP_OUT, OP_FIN, OP_PASS, OP_EMIT
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_TGT, S_DIFF, S_SPOOL, S_SQ, S_AMP, S_CHK, S_STEP, S_J1,
      S_J2, S_JIT, S_NC, S_FILT, S_MIXN, S_SIG, S_OUT, S_FIN, S_PASS, S_DONE
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic max_zero;
      logic audible;
   } status_type;

   // quarter-wave sine entry, ninth-order odd polynomial in Q30
   function automatic logic [15:0] sine_entry(input int unsigned idx,
                                              input int unsigned tbits);
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] e;
      u  = (64'(2 * idx + 1)) << (29 - tbits);
      u2 = (u * u) >> 30;
      p  = 64'd172272;
      p  = 64'd5026995 - ((u2 * p) >> 30);
      p  = 64'd85569306 - ((u2 * p) >> 30);
      p  = 64'd693598668 - ((u2 * p) >> 30);
      p  = 64'd1686629713 - ((u2 * p) >> 30);
      s  = (u * p) >> 30;
      e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) begin
         e = 64'd32767;
      end
      return e[15:0];
   endfunction

endpackage

// ===== rtl/twv_if.sv =====
interface twv_req_if import twv_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic [15:0]                   rpm_level;
   logic [15:0]                   throttle_level;
   logic signed [SAMPLE_BITS-1:0] existing_sample;
   logic                          frame_last;
   modport source(output valid, rpm_level, throttle_level, existing_sample, frame_last,
                  input ready);
   modport sink(input valid, rpm_level, throttle_level, existing_sample, frame_last,
                output ready);
endinterface

interface twv_rsp_if import twv_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] mixed_sample;
   logic                          last_of_block;
   modport source(output valid, mixed_sample, last_of_block, input ready);
   modport sink(input valid, mixed_sample, last_of_block, output ready);
endinterface

interface twv_csr_if import twv_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [15:0]          data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/twv_datapath.sv =====
`include "turbo_whistle_voice_assert.svh"

module twv_datapath import twv_pkg::*; #(
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic [15:0]                   rpm_level,
   input  logic [15:0]                   throttle_level,
   input  logic signed [SAMPLE_BITS-1:0] existing_sample,
   input  logic                          frame_last,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [15:0]                   csr_data,
   output logic signed [SAMPLE_BITS-1:0] mixed_sample,
   output logic                          last_of_block
);

   localparam int TBL_N = 1 << SINE_TABLE_BITS;
   localparam int PW    = 66;
   localparam logic signed [PW-1:0] SMP_MAX = (66'sd1 <<< (SAMPLE_BITS - 1)) - 66'sd1;
   localparam logic signed [PW-1:0] SMP_MIN = -(66'sd1 <<< (SAMPLE_BITS - 1));
   localparam logic signed [PW-1:0] RND     = 66'sd1 <<< (46 - SAMPLE_BITS);

   logic [15:0] sine_rom [TBL_N];
   for (genvar gi = 0; gi < TBL_N; gi++) begin : g_rom
      assign sine_rom[gi] = sine_entry(gi, SINE_TABLE_BITS);
   end

   logic [15:0] cfg_ff [NUM_CSR];
   logic [15:0] spool_ff, spool_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic signed [15:0] prev_ff, prev_in;
   logic [31:0] rng_ff [4];
   logic        draw_en;
   logic [31:0] draw_t;

   logic [15:0] rpm_ff, thr_ff;
   logic signed [SAMPLE_BITS-1:0] smp_ff;
   logic        last_ff;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [31:0] amp_ff, amp_in;
   logic [16:0] step_ff, step_in;
   logic [31:0] r1_ff, r1_in;
   logic signed [15:0] n_ff, n_in, tone_ff, tone_in;
   logic signed [17:0] filt_ff, filt_in;
   logic signed [34:0] acc_ff, acc_in;
   logic signed [19:0] sig_ff, sig_in;
   logic signed [SAMPLE_BITS-1:0] res_ff, res_in, mixed_ff;
   logic        lob_ff;

   logic signed [32:0] mul_a, mul_b;

   // scratch
   logic [15:0] target;
   logic signed [16:0] diff;
   logic signed [33:0] rnd_up;
   logic signed [18:0] sp_sum;
   logic signed [PW-1:0] jit, nc_sh, fin_add, fin_sum;
   logic signed [18:0] step2s;
   logic [17:0] step2;
   logic [PHASE_BITS+17:0] inc_w;
   logic [1:0] quad;
   logic [PHASE_BITS+SINE_TABLE_BITS-3:0] idx_w;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic signed [15:0] sv;
   logic signed [35:0] sig_sum;
   logic [31:0] w3x;

   assign status.max_zero = (cfg_ff[CSR_MAX_AMP] == 16'd0);
   assign status.audible  = (prod_ff[31:0] >= AMP_FLOOR);

   // xorshift128 draw from the current words
   always_comb begin
      w3x    = rng_ff[3] ^ (rng_ff[3] << 11);
      w3x    = w3x ^ (w3x >> 8);
      draw_t = w3x ^ rng_ff[0] ^ (rng_ff[0] >> 19);
   end

   // tone read from the current phase
   always_comb begin
      quad  = phase_ff[PHASE_BITS-1:PHASE_BITS-2];
      idx_w = {phase_ff[PHASE_BITS-3:0], {SINE_TABLE_BITS{1'b0}}} >> (PHASE_BITS - 2);
      idx   = quad[0] ? ~idx_w[SINE_TABLE_BITS-1:0] : idx_w[SINE_TABLE_BITS-1:0];
      sv    = $signed(sine_rom[idx]);
   end

   always_comb begin
      prod_in  = prod_ff;
      mul_a    = '0;
      mul_b    = '0;
      spool_in = spool_ff;
      phase_in = phase_ff;
      prev_in  = prev_ff;
      draw_en  = 1'b0;
      amp_in   = amp_ff;
      step_in  = step_ff;
      r1_in    = r1_ff;
      n_in     = n_ff;
      tone_in  = tone_ff;
      filt_in  = filt_ff;
      acc_in   = acc_ff;
      sig_in   = sig_ff;
      res_in   = res_ff;
      target   = prod_ff[31:16];
      diff     = $signed({1'b0, target}) - $signed({1'b0, spool_ff});
      rnd_up   = prod_ff[33:0] + 34'sd32768;
      sp_sum   = $signed({3'b0, spool_ff}) + 19'(rnd_up >>> 16);
      jit      = prod_ff >>> 47;
      step2s   = $signed({2'b0, step_ff}) + jit[18:0];
      step2    = step2s[18] ? 18'd0 : step2s[17:0];
      inc_w    = {step2, {PHASE_BITS{1'b0}}} >> 16;
      nc_sh    = prod_ff >>> 16;
      sig_sum  = $signed({acc_ff[34], acc_ff}) + prod_ff[35:0];
      fin_add  = (prod_ff + RND) >>> (47 - SAMPLE_BITS);
      fin_sum  = PW'(smp_ff) + fin_add;
      case (cmd.op)
         OP_TGT: begin
            mul_a = $signed({17'd0, rpm_ff});
            mul_b = $signed({17'd0, thr_ff});
         end
         OP_DIFF: begin
            mul_a = 33'(diff);
            mul_b = $signed({17'd0, (target > spool_ff) ? cfg_ff[CSR_SPOOL_UP]
                                                        : cfg_ff[CSR_SPOOL_DN]});
         end
         OP_SPOOL: begin
            if (sp_sum < 0) begin
               spool_in = 16'd0;
            end else if (sp_sum > 19'sd65535) begin
               spool_in = 16'hFFFF;
            end else begin
               spool_in = sp_sum[15:0];
            end
         end
         OP_SQ: begin
            mul_a = $signed({17'd0, spool_ff});
            mul_b = $signed({17'd0, spool_ff});
         end
         OP_AMP: begin
            mul_a = $signed({17'd0, cfg_ff[CSR_MAX_AMP]});
            mul_b = $signed({17'd0, prod_ff[31:16]});
         end
         OP_CHK: begin
            amp_in = prod_ff[31:0];
            mul_a  = $signed({17'd0, cfg_ff[CSR_RANGE_STEP]});
            mul_b  = $signed({17'd0, spool_ff});
         end
         OP_STEP: begin
            step_in = {1'b0, cfg_ff[CSR_BASE_STEP]} + {1'b0, prod_ff[31:16]};
            draw_en = 1'b1;
            r1_in   = draw_t;
         end
         OP_J1: begin
            mul_a = $signed({16'd0, step_ff});
            mul_b = $signed({22'd0, JITTER_Q16});
         end
         OP_J2: begin
            mul_a = $signed({5'd0, prod_ff[27:0]});
            mul_b = $signed({r1_ff[31], r1_ff});
         end
         OP_JIT: begin
            tone_in  = quad[1] ? -sv : sv;
            phase_in = phase_ff + inc_w[PHASE_BITS-1:0];
            draw_en  = 1'b1;
            n_in     = $signed(draw_t[31:16]);
         end
         OP_NC: begin
            mul_a = $signed({17'd0, cfg_ff[CSR_NOISE_COEF]});
            mul_b = 33'(prev_ff);
         end
         OP_FILT: begin
            filt_in = 18'(n_ff) - nc_sh[17:0];
            prev_in = n_ff;
            mul_a   = $signed(33'h10000 - {17'd0, cfg_ff[CSR_NOISE_MIX]});
            mul_b   = 33'(tone_ff);
         end
         OP_MIXN: begin
            acc_in = prod_ff[34:0];
            mul_a  = $signed({17'd0, cfg_ff[CSR_NOISE_MIX]});
            mul_b  = 33'(filt_ff);
         end
         OP_SIG: begin
            sig_in = 20'(sig_sum >>> 16);
         end
         OP_OUT: begin
            mul_a = $signed({1'b0, amp_ff});
            mul_b = 33'(sig_ff);
         end
         OP_FIN: begin
            if (fin_sum > SMP_MAX) begin
               res_in = SMP_MAX[SAMPLE_BITS-1:0];
            end else if (fin_sum < SMP_MIN) begin
               res_in = SMP_MIN[SAMPLE_BITS-1:0];
            end else begin
               res_in = fin_sum[SAMPLE_BITS-1:0];
            end
         end
         OP_PASS: begin
            res_in = smp_ff;
         end
         default: begin
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CSR_BASE_STEP]  <= BASE_STEP_RST;
         cfg_ff[CSR_RANGE_STEP] <= RANGE_STEP_RST;
         cfg_ff[CSR_NOISE_MIX]  <= NOISE_MIX_RST;
         cfg_ff[CSR_MAX_AMP]    <= MAX_AMP_RST;
         cfg_ff[CSR_SPOOL_UP]   <= SPOOL_UP_RST;
         cfg_ff[CSR_SPOOL_DN]   <= SPOOL_DN_RST;
         cfg_ff[CSR_NOISE_COEF] <= NOISE_COEF_RST;
         spool_ff  <= '0;
         phase_ff  <= '0;
         prev_ff   <= '0;
         rng_ff[0] <= SEED0;
         rng_ff[1] <= SEED1;
         rng_ff[2] <= SEED2;
         rng_ff[3] <= SEED3;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_STEP:  cfg_ff[CSR_BASE_STEP]  <= csr_data;
               CSR_RANGE_STEP: cfg_ff[CSR_RANGE_STEP] <= csr_data;
               CSR_NOISE_MIX:  cfg_ff[CSR_NOISE_MIX]  <= csr_data;
               CSR_MAX_AMP:    cfg_ff[CSR_MAX_AMP]    <= csr_data;
               CSR_SPOOL_UP:   cfg_ff[CSR_SPOOL_UP]   <= csr_data;
               CSR_SPOOL_DN:   cfg_ff[CSR_SPOOL_DN]   <= csr_data;
               CSR_NOISE_COEF: cfg_ff[CSR_NOISE_COEF] <= csr_data;
               default: begin
               end
            endcase
         end
         spool_ff <= spool_in;
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         if (draw_en) begin
            rng_ff[0] <= draw_t;
            rng_ff[1] <= rng_ff[0];
            rng_ff[2] <= rng_ff[1];
            rng_ff[3] <= rng_ff[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LATCH) begin
         rpm_ff  <= rpm_level;
         thr_ff  <= throttle_level;
         smp_ff  <= existing_sample;
         last_ff <= frame_last;
      end
      if (cmd.op == OP_EMIT) begin
         mixed_ff <= res_ff;
         lob_ff   <= last_ff;
      end
      prod_ff <= prod_in;
      amp_ff  <= amp_in;
      step_ff <= step_in;
      r1_ff   <= r1_in;
      n_ff    <= n_in;
      tone_ff <= tone_in;
      filt_ff <= filt_in;
      acc_ff  <= acc_in;
      sig_ff  <= sig_in;
      res_ff  <= res_in;
   end

   assign mixed_sample  = mixed_ff;
   assign last_of_block = lob_ff;

   `TWV_ASSERT(a_phase_hold, clock, reset, (cmd.op != OP_JIT) |=> $stable(phase_ff), "phase moved outside tone step")
   `TWV_ASSERT(a_rng_hold, clock, reset, (cmd.op != OP_STEP && cmd.op != OP_JIT) |=> $stable(rng_ff[0]), "rng drew outside draw steps")
   `TWV_ASSERT(a_spool_hold, clock, reset, (cmd.op != OP_SPOOL) |=> $stable(spool_ff), "spool moved outside update step")

endmodule

// ===== rtl/twv_ctrl.sv =====
`include "turbo_whistle_voice_assert.svh"

module twv_ctrl import twv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = status.max_zero ? S_PASS : S_TGT;
            end
         end
         S_TGT:   begin cmd.op = OP_TGT;   state_in = S_DIFF;  end
         S_DIFF:  begin cmd.op = OP_DIFF;  state_in = S_SPOOL; end
         S_SPOOL: begin cmd.op = OP_SPOOL; state_in = S_SQ;    end
         S_SQ:    begin cmd.op = OP_SQ;    state_in = S_AMP;   end
         S_AMP:   begin cmd.op = OP_AMP;   state_in = S_CHK;   end
         S_CHK: begin
            cmd.op   = OP_CHK;
            state_in = status.audible ? S_STEP : S_PASS;
         end
         S_STEP:  begin cmd.op = OP_STEP;  state_in = S_J1;    end
         S_J1:    begin cmd.op = OP_J1;    state_in = S_J2;    end
         S_J2:    begin cmd.op = OP_J2;    state_in = S_JIT;   end
         S_JIT:   begin cmd.op = OP_JIT;   state_in = S_NC;    end
         S_NC:    begin cmd.op = OP_NC;    state_in = S_FILT;  end
         S_FILT:  begin cmd.op = OP_FILT;  state_in = S_MIXN;  end
         S_MIXN:  begin cmd.op = OP_MIXN;  state_in = S_SIG;   end
         S_SIG:   begin cmd.op = OP_SIG;   state_in = S_OUT;   end
         S_OUT:   begin cmd.op = OP_OUT;   state_in = S_FIN;   end
         S_FIN:   begin cmd.op = OP_FIN;   state_in = S_DONE;  end
         S_PASS:  begin cmd.op = OP_PASS;  state_in = S_DONE;  end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `TWV_ASSERT(a_leave_idle, clock, reset, (state_ff == S_IDLE && req_valid) |=> (state_ff != S_IDLE), "accepted item did not start")
   `TWV_ASSERT(a_emit_valid, clock, reset, (cmd.op == OP_EMIT) |=> rsp_valid_ff, "emitted item not shown")
   `TWV_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && !rsp_valid_ff), "reset left work pending")

endmodule

// ===== rtl/turbo_whistle_voice.sv =====
// Turbo whistle voice: one input item per audio sample. The spool level tracks
// rpm times throttle with separate rise and fall rates; when the resulting
// amplitude (peak gain register times spool squared) is audible, a jittered sine
// tone mixed with filtered xorshift noise is added to existing_sample with
// saturation. One shared 33x33 multiplier, stepped by the controller, does all
// products, so the block takes no new item until the last one is done; an
// inaudible sample skips the tone steps and one with zero peak gain skips all.
// A finished result also waits until the previous one has left the output
// register through rsp.ready before the block is ready again.
// The next item is taken while the previous result still waits in the output
// register. Configuration is written through the csr channel, never stalled.
// The user writes it only while no item is in flight; the block does not check.
module turbo_whistle_voice import twv_pkg::*; #(
   parameter int PHASE_BITS      = PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   twv_req_if.sink  req,
   twv_rsp_if.source rsp,
   twv_csr_if.sink  csr
);

   cmd_type    cmd;
   status_type status;

   // registers always take a write
   assign csr.ready = 1'b1;

   twv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   twv_datapath #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rpm_level       (req.rpm_level),
      .throttle_level  (req.throttle_level),
      .existing_sample (req.existing_sample),
      .frame_last      (req.frame_last),
      .csr_we          (csr.valid),
      .csr_index       (csr.index),
      .csr_data        (csr.data),
      .mixed_sample    (rsp.mixed_sample),
      .last_of_block   (rsp.last_of_block)
   );

endmodule

// ===== verif/turbo_whistle_voice_tb.sv =====
module turbo_whistle_voice_tb import twv_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // input item as it goes onto the req channel
   typedef struct {
      logic [15:0]        rpm;
      logic [15:0]        thr;
      logic signed [15:0] smp;
      logic               last;
   } sample_req_type;

   // one result item off the rsp channel
   typedef struct {
      logic signed [15:0] mixed;
      logic               last;
   } mixed_rsp_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;   // margin beyond the audible path, the longest one

   logic clock = 1'b0;
   logic reset = 1'b1;

   twv_req_if req_ch ();
   twv_rsp_if rsp_ch ();
   twv_csr_if csr_ch ();

   turbo_whistle_voice DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ------------------------------------------------------------------
   // Whistle predictor: own copy of registers and voice state
   // ------------------------------------------------------------------
   logic [15:0] reg_val [NUM_CSR];
   logic [15:0] spool_q;
   logic [15:0] phase_q;
   logic [15:0] last_noise_q;
   logic [31:0] xs_word [4];
   longint      quarter_sine [256];

   sample_req_type pending_samples [$];
   mixed_rsp_type  expected_mix [$];
   int             fail_count = 0;

   // quarter-wave table, odd ninth-order polynomial in Q30
   function automatic longint sine_poly(int unsigned i);
      longint unsigned u, u2, p, s, e;
      u  = longint'(2 * i + 1) << 21;
      u2 = (u * u) >> 30;
      p  = 172272;
      p  = 5026995 - ((u2 * p) >> 30);
      p  = 85569306 - ((u2 * p) >> 30);
      p  = 693598668 - ((u2 * p) >> 30);
      p  = 1686629713 - ((u2 * p) >> 30);
      s  = (u * p) >> 30;
      e  = (s * 32767 + (64'd1 << 29)) >> 30;
      if (e > 32767) e = 32767;
      return longint'(e);
   endfunction

   // xorshift128 step
   function automatic logic [31:0] xs_draw();
      logic [31:0] t, w0;
      t  = xs_word[3];
      w0 = xs_word[0];
      t  = t ^ (t << 11);
      t  = t ^ (t >> 8);
      xs_word[3] = xs_word[2];
      xs_word[2] = xs_word[1];
      xs_word[1] = w0;
      t  = t ^ w0 ^ (w0 >> 19);
      xs_word[0] = t;
      return t;
   endfunction

   function automatic longint tone_at(logic [15:0] ph);
      logic [7:0] idx;
      longint     v;
      idx = ph[13:6];
      if (ph[14]) idx = 8'd255 - idx;
      v = quarter_sine[idx];
      return ph[15] ? -v : v;
   endfunction

   function automatic void voice_reset();
      reg_val[CSR_BASE_STEP]  = BASE_STEP_RST;
      reg_val[CSR_RANGE_STEP] = RANGE_STEP_RST;
      reg_val[CSR_NOISE_MIX]  = NOISE_MIX_RST;
      reg_val[CSR_MAX_AMP]    = MAX_AMP_RST;
      reg_val[CSR_SPOOL_UP]   = SPOOL_UP_RST;
      reg_val[CSR_SPOOL_DN]   = SPOOL_DN_RST;
      reg_val[CSR_NOISE_COEF] = NOISE_COEF_RST;
      spool_q      = '0;
      phase_q      = '0;
      last_noise_q = '0;
      xs_word[0] = SEED0;
      xs_word[1] = SEED1;
      xs_word[2] = SEED2;
      xs_word[3] = SEED3;
      for (int i = 0; i < 256; i++) quarter_sine[i] = sine_poly(i);
   endfunction

   // one sample tick; all right shifts of signed values floor (>>> on longint)
   function automatic mixed_rsp_type predict_mix(sample_req_type it);
      mixed_rsp_type r;
      longint        tgt, sp, k, s2, amp, step, r1s, tone, n, pn, filt, sig, add, res;
      logic [31:0]   r1, r2;
      res = longint'(it.smp);
      if (reg_val[CSR_MAX_AMP] != 16'd0) begin
         tgt = (longint'(it.rpm) * longint'(it.thr)) >>> 16;
         sp  = longint'(spool_q);
         k   = (tgt > sp) ? longint'(reg_val[CSR_SPOOL_UP]) : longint'(reg_val[CSR_SPOOL_DN]);
         sp  = sp + (((tgt - sp) * k + 32768) >>> 16);
         if (sp < 0) sp = 0;
         if (sp > 65535) sp = 65535;
         spool_q = sp[15:0];
         s2  = (sp * sp) >>> 16;
         amp = longint'(reg_val[CSR_MAX_AMP]) * s2;
         if (amp >= longint'(AMP_FLOOR)) begin
            step = longint'(reg_val[CSR_BASE_STEP])
                 + ((longint'(reg_val[CSR_RANGE_STEP]) * sp) >>> 16);
            r1   = xs_draw();
            r1s  = longint'($signed(r1));
            step = step + ((step * r1s * longint'(JITTER_Q16)) >>> 47);
            if (step < 0) step = 0;
            // tone comes from the phase before it advances
            tone    = tone_at(phase_q);
            phase_q = phase_q + step[15:0];
            r2   = xs_draw();
            n    = longint'($signed(r2[31:16]));
            pn   = longint'($signed(last_noise_q));
            filt = n - ((longint'(reg_val[CSR_NOISE_COEF]) * pn) >>> 16);
            last_noise_q = r2[31:16];
            sig  = ((65536 - longint'(reg_val[CSR_NOISE_MIX])) * tone
                   + longint'(reg_val[CSR_NOISE_MIX]) * filt) >>> 16;
            // final scaling rounds to nearest, ties up
            add  = (amp * sig + (longint'(1) <<< 30)) >>> 31;
            res  = res + add;
            if (res > 32767) res = 32767;
            if (res < -32768) res = -32768;
         end
      end
      r.mixed = res[15:0];
      r.last  = it.last;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: fed from pending_samples, random gap per item
   // ------------------------------------------------------------------
   logic req_took   = 1'b0;   // set at the edge an item was taken
   int   req_gap    = 0;
   logic gaps_on    = 1'b1;   // stretches with no idling when low

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_took) begin
         // hold the item until the block takes it
      end else if (req_gap > 0) begin
         req_gap--;
         req_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
         sample_req_type it;
         it = pending_samples.pop_front();
         req_ch.valid           <= 1'b1;
         req_ch.rpm_level       <= it.rpm;
         req_ch.throttle_level  <= it.thr;
         req_ch.existing_sample <= it.smp;
         req_ch.frame_last      <= it.last;
         req_gap = gaps_on ? $urandom_range(0, 6) : 0;
      end else begin
         req_ch.valid <= 1'b0;
      end
      req_took = 1'b0;
   end

   // prediction happens at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sample_req_type it;
         it.rpm  = req_ch.rpm_level;
         it.thr  = req_ch.throttle_level;
         it.smp  = req_ch.existing_sample;
         it.last = req_ch.frame_last;
         expected_mix.push_back(predict_mix(it));
         req_took = 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Result monitor with random back-pressure
   // ------------------------------------------------------------------
   int rsp_stall = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         mixed_rsp_type want;
         if (expected_mix.size() == 0) begin
            $error("result item with nothing expected: mixed_sample %0d", rsp_ch.mixed_sample);
            fail_count++;
         end else begin
            want = expected_mix.pop_front();
            if (rsp_ch.mixed_sample !== want.mixed) begin
               $error("mixed_sample: expected %0d, got %0d", want.mixed, rsp_ch.mixed_sample);
               fail_count++;
            end
            if (rsp_ch.last_of_block !== want.last) begin
               $error("last_of_block: expected %0b, got %0b", want.last, rsp_ch.last_of_block);
               fail_count++;
            end
         end
         rsp_stall = gaps_on ? $urandom_range(0, 6) : 0;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: cycles without any accepted item on any channel
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequencing
   // ------------------------------------------------------------------
   // register write; only called with the voice idle
   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      reg_val[idx] = val;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // wait for every queued item to go and every result to come back
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_ch.valid || expected_mix.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_sample(logic [15:0] rpm, logic [15:0] thr, logic [15:0] smp, logic last);
      sample_req_type it;
      it.rpm  = rpm;
      it.thr  = thr;
      it.smp  = smp;
      it.last = last;
      pending_samples.push_back(it);
   endtask

   // extremes a third of the time, otherwise anything
   function automatic logic [15:0] pick_reg();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   // a run of samples: mostly held engine conditions with small drift, some jumps
   task automatic random_run(int count);
      logic [15:0] rpm, thr;
      rpm = 16'($urandom());
      thr = 16'($urandom());
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               rpm = 16'($urandom());
               thr = 16'($urandom());
            end
            2: begin
               rpm = 16'hFFFF;
               thr = 16'hFFFF;
            end
            3: thr = 16'h0000;
            default: begin
               rpm = rpm + 16'($urandom_range(0, 512)) - 16'd256;
               thr = thr + 16'($urandom_range(0, 512)) - 16'd256;
            end
         endcase
         push_sample(rpm, thr, 16'($urandom()), ($urandom_range(0, 15) == 0));
         if ($urandom_range(0, 60) == 0) gaps_on = !gaps_on;
      end
   endtask

   initial begin
      req_ch.valid           = 1'b0;
      req_ch.rpm_level       = '0;
      req_ch.throttle_level  = '0;
      req_ch.existing_sample = '0;
      req_ch.frame_last      = 1'b0;
      rsp_ch.ready           = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = CSR_BASE_STEP;
      csr_ch.data            = '0;
      voice_reset();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: zero max amplitude, every sample passes unchanged
      push_sample(16'hFFFF, 16'hFFFF, 16'sh7FFF, 1'b0);
      push_sample(16'h0000, 16'h0000, 16'sh8000, 1'b1);
      push_sample(16'hFFFF, 16'h0000, 16'h0001, 1'b0);
      wait_idle();

      // full gain, instant spool: drive to saturation both ways
      write_reg(CSR_BASE_STEP,  16'd2731);
      write_reg(CSR_RANGE_STEP, 16'hFFFF);
      write_reg(CSR_NOISE_MIX,  16'h8000);
      write_reg(CSR_MAX_AMP,    16'hFFFF);
      write_reg(CSR_SPOOL_UP,   16'hFFFF);
      write_reg(CSR_SPOOL_DN,   16'hFFFF);
      write_reg(CSR_NOISE_COEF, 16'd59022);
      for (int i = 0; i < 6; i++) push_sample(16'hFFFF, 16'hFFFF, 16'sh7FFF, i[0]);
      for (int i = 0; i < 6; i++) push_sample(16'hFFFF, 16'hFFFF, 16'sh8000, i[0]);
      push_sample(16'h0000, 16'hFFFF, 16'h0000, 1'b1);   // spool falls away
      push_sample(16'h0000, 16'h0000, 16'h0000, 1'b0);
      wait_idle();

      // noise share at its largest leaves a trace of tone
      write_reg(CSR_NOISE_MIX, 16'hFFFF);
      for (int i = 0; i < 4; i++) push_sample(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
      wait_idle();

      // slow rates: target just below the spool leaves a step of zero
      write_reg(CSR_SPOOL_UP, 16'd3);
      write_reg(CSR_SPOOL_DN, 16'd5);
      write_reg(CSR_NOISE_MIX, 16'h0000);
      for (int i = 0; i < 5; i++) push_sample(16'hFFF0, 16'hFFFF, 16'h0100, 1'b0);
      wait_idle();

      // random phases, each under its own register setting
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_BASE_STEP,  pick_reg());
         write_reg(CSR_RANGE_STEP, pick_reg());
         write_reg(CSR_NOISE_MIX,  pick_reg());
         write_reg(CSR_MAX_AMP,    (ph == 2) ? 16'h0000 : (($urandom_range(0, 2) == 0) ?
                                   16'hFFFF : 16'($urandom_range(1, 65535))));
         write_reg(CSR_SPOOL_UP,   ($urandom_range(0, 1) != 0) ? pick_reg() :
                                   16'($urandom_range(2000, 65535)));
         write_reg(CSR_SPOOL_DN,   pick_reg());
         write_reg(CSR_NOISE_COEF, pick_reg());
         random_run(85);
         // sender holds off until the voice has drained
         wait_idle();
         random_run(85);
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
